FILE: rtl/core/irpd_pkg.sv
package irpd_pkg;

    localparam int unsigned LEN_W     = 8;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned COUNT_W   = 8;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 8;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_MIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_MIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEADER_MIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_END_MIN    = 3'd4;

    // Threshold reset values
    localparam logic [LEN_W-1:0] ZERO_MIN_RST   = 8'd10;
    localparam logic [LEN_W-1:0] ONE_MIN_RST    = 8'd50;
    localparam logic [LEN_W-1:0] REPEAT_MIN_RST = 8'd100;
    localparam logic [LEN_W-1:0] LEADER_MIN_RST = 8'd200;
    localparam logic [LEN_W-1:0] END_MIN_RST    = 8'd250;

    typedef struct packed {
        logic [LEN_W-1:0] zero_min;
        logic [LEN_W-1:0] one_min;
        logic [LEN_W-1:0] repeat_min;
        logic [LEN_W-1:0] leader_min;
        logic [LEN_W-1:0] end_min;
    } t_thresh;

    typedef struct packed {
        logic               leader_seen;
        logic               held_bit;
        logic [WORD_W-1:0]  shift_word;
        logic [COUNT_W-1:0] repeat_count;
        logic [COUNT_W-1:0] entry_tally;
    } t_dec_state;

    typedef struct packed {
        logic repeat_seen;
        logic burst_end;
    } t_flags;

endpackage

FILE: rtl/core/irpd_cfg.sv
module irpd_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [irpd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [irpd_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    output irpd_pkg::t_thresh               o_thresh
);

    irpd_pkg::t_thresh r_thresh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh.zero_min   <= irpd_pkg::ZERO_MIN_RST;
            r_thresh.one_min    <= irpd_pkg::ONE_MIN_RST;
            r_thresh.repeat_min <= irpd_pkg::REPEAT_MIN_RST;
            r_thresh.leader_min <= irpd_pkg::LEADER_MIN_RST;
            r_thresh.end_min    <= irpd_pkg::END_MIN_RST;
        end else if (i_cfg_valid) begin
            // drop writes to unknown indexes
            unique case (i_cfg_index)
                irpd_pkg::REG_ZERO_MIN:   r_thresh.zero_min   <= i_cfg_data;
                irpd_pkg::REG_ONE_MIN:    r_thresh.one_min    <= i_cfg_data;
                irpd_pkg::REG_REPEAT_MIN: r_thresh.repeat_min <= i_cfg_data;
                irpd_pkg::REG_LEADER_MIN: r_thresh.leader_min <= i_cfg_data;
                irpd_pkg::REG_END_MIN:    r_thresh.end_min    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_thresh = r_thresh;

endmodule

FILE: rtl/core/irpd_class.sv
module irpd_class (
    input  logic [irpd_pkg::LEN_W-1:0] i_pulse_len,
    input  irpd_pkg::t_thresh          i_thresh,
    input  irpd_pkg::t_dec_state       i_state,
    output irpd_pkg::t_dec_state       o_state,
    output irpd_pkg::t_flags           o_flags
);

    logic is_end;
    logic is_leader;
    logic is_zero;
    logic is_one;
    logic is_repeat;
    logic leader_nxt;
    logic held_nxt;

    always_comb begin
        // classes tested in priority order, first match wins
        is_end    = i_pulse_len >= i_thresh.end_min;
        is_leader = !is_end && (i_pulse_len >= i_thresh.leader_min);
        is_zero   = !is_end && !is_leader
                    && (i_pulse_len >= i_thresh.zero_min) && (i_pulse_len < i_thresh.one_min);
        is_one    = !is_end && !is_leader && !is_zero
                    && (i_pulse_len >= i_thresh.one_min) && (i_pulse_len < i_thresh.repeat_min);
        is_repeat = !is_end && !is_leader && !is_zero && !is_one
                    && (i_pulse_len >= i_thresh.repeat_min)
                    && (i_pulse_len <= i_thresh.leader_min);

        leader_nxt = i_state.leader_seen | is_leader;
        held_nxt   = is_zero ? 1'b0 : (is_one ? 1'b1 : i_state.held_bit);

        o_state = i_state;
        if (is_repeat) begin
            o_state.repeat_count = i_state.repeat_count + 1'b1;
            o_state.entry_tally  = i_state.entry_tally + 1'b1;
        end

        if (is_end || is_repeat) begin
            o_state.leader_seen = 1'b0;
            o_state.held_bit    = 1'b0;
        end else begin
            o_state.leader_seen = leader_nxt;
            o_state.held_bit    = held_nxt;
            if (leader_nxt) begin
                o_state.shift_word   = {i_state.shift_word[irpd_pkg::WORD_W-2:0], held_nxt};
                o_state.repeat_count = '0;
                o_state.entry_tally  = irpd_pkg::COUNT_W'(1);
            end
        end

        o_flags.repeat_seen = is_repeat;
        o_flags.burst_end   = is_end | is_repeat;
    end

endmodule

FILE: rtl/core/ir_pulse_width_frame_decoder.sv
// IR pulse-width frame decoder.
// Input channel: i_in_valid / o_in_stall carry one measured pulse length
// (i_pulse_len) per transfer. Output channel: o_out_valid / i_out_stall carry
// one result per pulse: frame word, press and entry counts, repeat and burst
// end flags. Each result is the decoder state just after that pulse.
// Configuration: i_cfg_valid / o_cfg_ready write one of five thresholds
// (index 0..4: zero, one, repeat, leader, end); other indexes are ignored.
// Write thresholds only while no pulse is in flight.
// Pipeline: a taken pulse loads the input register; it is then classified
// and loaded into the result register, which drives o_out_valid, unless a
// result held under i_out_stall keeps it waiting.
// Throughput: one pulse per cycle while no result is held under i_out_stall;
// the classify/shift logic between the two registers is the only work on each pulse.
// Stall: while a result waits under i_out_stall the input register still
// fills; once it is full too, o_in_stall rises. A stalled result holds.
// Reset (synchronous, active low): thresholds return to 10/50/100/200/250,
// the frame word and counts clear, the burst restarts without a leader.
module ir_pulse_width_frame_decoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [irpd_pkg::LEN_W-1:0]      i_pulse_len,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [irpd_pkg::WORD_W-1:0]     o_frame_word,
    output logic [irpd_pkg::COUNT_W-1:0]    o_press_count,
    output logic [irpd_pkg::COUNT_W-1:0]    o_entry_count,
    output logic                            o_repeat_seen,
    output logic                            o_burst_end,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [irpd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [irpd_pkg::CFG_DAT_W-1:0]  i_cfg_data
);

    irpd_pkg::t_thresh    thresh;
    irpd_pkg::t_dec_state n_state;
    irpd_pkg::t_flags     n_flags;

    logic                         r_in_vld;
    logic [irpd_pkg::LEN_W-1:0]   r_in_len;
    logic                         r_out_vld;
    irpd_pkg::t_dec_state         r_state;
    irpd_pkg::t_flags             r_flags;

    logic out_hold;
    logic s1_fire;
    logic in_take;

    assign o_cfg_ready = 1'b1;

    irpd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_thresh    (thresh)
    );

    irpd_class u_class (
        .i_pulse_len (r_in_len),
        .i_thresh    (thresh),
        .i_state     (r_state),
        .o_state     (n_state),
        .o_flags     (n_flags)
    );

    assign out_hold   = r_out_vld & i_out_stall;
    assign s1_fire    = r_in_vld & !out_hold;
    assign o_in_stall = r_in_vld & out_hold;
    assign in_take    = i_in_valid & !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!out_hold) begin
            r_in_vld <= in_take;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_len <= i_pulse_len;
        end
    end

    // decoder state doubles as the result register: advance only on a move
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_state   <= '0;
            r_flags   <= '0;
        end else if (!out_hold) begin
            r_out_vld <= s1_fire;
            if (s1_fire) begin
                r_state <= n_state;
                r_flags <= n_flags;
            end
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_frame_word  = r_state.shift_word;
    assign o_press_count = r_state.repeat_count;
    assign o_entry_count = r_state.entry_tally;
    assign o_repeat_seen = r_flags.repeat_seen;
    assign o_burst_end   = r_flags.burst_end;

endmodule
